// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the weight update engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define MRWU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MRWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MRWU_ASSERT_IMPL(lbl, ante, cons, msg)
`define MRWU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/mrwu_pkg.sv =====
// Package with types, constants and arithmetic helpers of the weight update engine.
`timescale 1ns / 1ps

package mrwu_pkg;

  localparam int ENTRIES = 4096;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ENTRY_W = 12;
  localparam int MEM_W   = 48;
  localparam int NUM_W   = 56;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADAGRAD       = 2'd2;

  localparam logic [23:0] LR_RESET   = 24'd167772;
  localparam logic [15:0] VISC_RESET = 16'd58982;
  localparam logic [15:0] ADA_RESET  = 16'd0;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [63:0] EPS_SMALL = 64'd43;
  localparam logic [63:0] EPS_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] RND_HALF  = 64'h8000;
  localparam logic [47:0] MEM_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam int          ROOT_PRESHIFT = 14;

  // Square root: 32 steps, two per stage.
  localparam int SQ_STEPS   = 32;
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = SQ_STEPS / SQ_PER;
  localparam int SQ_TOP_BIT = 62;

  // Division: one quotient bit per step, two per stage.
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = NUM_W / DIV_PER;

  typedef struct packed {
    logic               action;
    logic [11:0]        entry_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic               end_of_pass;
  } in_t;

  typedef struct packed {
    logic [11:0]        entry_out;
    logic signed [31:0] weight_out;
  } out_t;

  // Item fields that ride along through the root and divide units.
  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] w_base;
    logic               neg;
    logic signed [31:0] mdec;
    logic [MEM_W-1:0]   mem;
  } side_t;

  typedef struct packed {
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [NUM_W-1:0] num;
    side_t            sb;
  } sq_st_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] q;
    logic [31:0]      dsr;
    side_t            sb;
  } dv_st_t;

  // Front pipeline item: each stage fills in its own fields.
  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] g;
    logic signed [31:0] w_base;
    logic               warm_v;
    logic               warm_a;
    logic signed [31:0] m_old;
    logic [MEM_W-1:0]   mem;
    logic signed [49:0] pv;
    logic [63:0]        gg;
    logic signed [31:0] m;
    logic [MEM_W-1:0]   sq;
    logic [63:0]        pa;
    logic [NUM_W-1:0]   num;
    logic signed [48:0] pm;
    logic signed [31:0] mdec;
    logic [63:0]        x;
    logic [63:0]        pmem;
  } fr_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Divide by 2^16, round to nearest, ties away from zero.
  function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [47:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = 48'((mag + RND_HALF) >> 16);
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== rtl/mrwu_isqrt.sv =====
// Pipelined integer square root with item fields carried alongside.
`timescale 1ns / 1ps

module mrwu_isqrt import mrwu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  sq_st_t           in_s,
  input  logic [IDX_W-1:0] probe_idx,
  output logic             hit,
  output logic             out_v,
  output sq_st_t           out_s
);

  logic [SQ_STAGES-1:0] v_r;
  sq_st_t               s_r [SQ_STAGES];

  function automatic sq_st_t sq_steps(input sq_st_t s, input int k);
    sq_st_t      o;
    logic [63:0] bitv;
    logic [63:0] trial;
    o = s;
    for (int t = 0; t < SQ_PER; t++) begin
      bitv  = 64'd1 << (SQ_TOP_BIT - 2 * (k * SQ_PER + t));
      trial = o.res + bitv;
      if (o.rem >= trial) begin
        o.rem = o.rem - trial;
        o.res = (o.res >> 1) + bitv;
      end else begin
        o.res = o.res >> 1;
      end
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_STAGES-2:0], in_v};
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    sq_st_t s_nxt;
    if (k == 0) begin : g_first
      assign s_nxt = sq_steps(in_s, k);
    end else begin : g_rest
      assign s_nxt = sq_steps(s_r[k-1], k);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_nxt;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (v_r[k] && s_r[k].sb.idx == probe_idx) begin
        hit = 1'b1;
      end
    end
  end

  assign out_v = v_r[SQ_STAGES-1];
  assign out_s = s_r[SQ_STAGES-1];

endmodule

// ===== rtl/mrwu_div.sv =====
// Pipelined restoring divider with item fields carried alongside.
`timescale 1ns / 1ps

module mrwu_div import mrwu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  dv_st_t           in_s,
  input  logic [IDX_W-1:0] probe_idx,
  output logic             hit,
  output logic             out_v,
  output dv_st_t           out_s
);

  logic [DIV_STAGES-1:0] v_r;
  dv_st_t                s_r [DIV_STAGES];

  function automatic dv_st_t dv_steps(input dv_st_t s);
    dv_st_t      o;
    logic [32:0] t33;
    o = s;
    for (int t = 0; t < DIV_PER; t++) begin
      t33   = {o.rem, o.num[NUM_W-1]};
      o.num = o.num << 1;
      if (t33 >= {1'b0, o.dsr}) begin
        o.rem = 32'(t33 - {1'b0, o.dsr});
        o.q   = {o.q[NUM_W-2:0], 1'b1};
      end else begin
        o.rem = t33[31:0];
        o.q   = {o.q[NUM_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_v};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    dv_st_t s_nxt;
    if (k == 0) begin : g_first
      assign s_nxt = dv_steps(in_s);
    end else begin : g_rest
      assign s_nxt = dv_steps(s_r[k-1]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k] <= s_nxt;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (v_r[k] && s_r[k].sb.idx == probe_idx) begin
        hit = 1'b1;
      end
    end
  end

  assign out_v = v_r[DIV_STAGES-1];
  assign out_s = s_r[DIV_STAGES-1];

endmodule

// ===== rtl/momentum_rms_weight_update.sv =====
// Top level of the momentum and RMS-normalized weight update engine.
`timescale 1ns / 1ps

// This engine holds 4096 fixed-point weights (Q8.24) together with a momentum
// and a squared-gradient memory for each of them. A load transaction writes a
// weight and clears its momentum and memory; an update transaction folds a
// gradient into momentum and memory, steps the weight by
// learning_rate * momentum / sqrt(memory + eps) and then decays both; memory
// is touched only while the adagrad rate is nonzero. Every input transaction
// produces exactly one result transaction carrying the entry index and the
// weight it now holds. The engine pipelines a table read stage, six multiply
// and add stages, sixteen square root stages at two result bits each,
// twenty-eight division stages at two quotient bits each and the output
// register. Transactions to distinct entries are accepted one per cycle
// unless the output stalls. A transaction that addresses an entry still in
// flight waits until that entry has been written back. After reset the
// engine clears the momentum and memory tables, one entry per cycle, taking
// no transaction meanwhile; configuration writes are taken at any time but
// are meant to be made only while the engine is idle.

`include "assert_macros.svh"

module momentum_rms_weight_update import mrwu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [23:0] lr_r;
  logic [15:0] visc_r;
  logic [15:0] ada_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LR_RESET;
      visc_r <= VISC_RESET;
      ada_r  <= ADA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE: lr_r   <= cfg_wdata;
        REG_VISCOSITY:     visc_r <= cfg_wdata[15:0];
        REG_ADAGRAD:       ada_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // One minus each decay rate, as 17-bit Q.16 values.
  logic [16:0] omv;
  logic [16:0] oma;
  logic        ada_on;

  assign omv    = 17'h10000 - 17'(visc_r);
  assign oma    = 17'h10000 - 17'(ada_r);
  assign ada_on = (ada_r != 16'd0);

  // Flow control. The whole pipeline moves together whenever the output
  // register is free or being emptied; valid bits travel with the data.
  logic             adv;
  logic             hazard;
  logic             in_fire;
  logic [IDX_W-1:0] in_idx;
  logic             clr_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             out_valid_r;
  out_t             out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_idx   = IDX_W'(in_data.entry_index % ENTRIES);
  assign in_ready = adv && !clr_r && !hazard;
  assign in_fire  = in_valid && in_ready;

  // The iteration counter moves at acceptance, so every transaction judges
  // warm-up against the count left by all transactions before it.
  logic [31:0] count_r;
  logic [31:0] count_nxt;
  logic        warm_v_in;
  logic        warm_a_in;

  assign warm_v_in = (49'(count_r) * 49'(omv)) < 49'h10000;
  assign warm_a_in = (49'(count_r) * 49'(oma)) < 49'h10000;

  always_comb begin
    count_nxt = count_r;
    if (in_fire && in_data.action == ACT_UPDATE && in_data.end_of_pass &&
        count_r != 32'hFFFF_FFFF) begin
      count_nxt = count_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Clearing pass over the momentum and memory tables after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(ENTRIES - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Parameter tables with registered reads.
  logic signed [31:0] wt_mem [ENTRIES];
  logic signed [31:0] mo_mem [ENTRIES];
  logic [MEM_W-1:0]   me_mem [ENTRIES];
  logic signed [31:0] w_rd_r;
  logic signed [31:0] m_rd_r;
  logic [MEM_W-1:0]   mem_rd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_rd_r   <= wt_mem[in_idx];
      m_rd_r   <= mo_mem[in_idx];
      mem_rd_r <= me_mem[in_idx];
    end
  end

  // Front stages: momentum, memory, products and the root operand.
  logic [6:0] fv_r;
  fr_t        st1_r, st2_r, st3_r, st4_r, st5_r, st6_r, st7_r;
  fr_t        st1_nxt, st2_nxt, st3_nxt, st4_nxt, st5_nxt, st6_nxt, st7_nxt;

  always_comb begin
    logic [31:0]        ga;
    logic [31:0]        mm;
    logic signed [63:0] inc;
    logic [MEM_W-1:0]   add;
    logic [MEM_W:0]     msum;
    logic [MEM_W-1:0]   mem5;
    logic [63:0]        eps;

    // Stage 1: the transaction itself, table read under way.
    st1_nxt        = st1_r;
    st1_nxt.action = in_data.action;
    st1_nxt.idx    = in_idx;
    st1_nxt.g      = in_data.gradient;
    st1_nxt.w_base = in_data.weight_in;
    st1_nxt.warm_v = warm_v_in;
    st1_nxt.warm_a = warm_a_in;

    // Stage 2: gradient products. A load keeps its own weight.
    ga             = st1_r.g[31] ? 32'(-st1_r.g) : 32'(st1_r.g);
    st2_nxt        = st1_r;
    st2_nxt.w_base = (st1_r.action == ACT_UPDATE) ? w_rd_r : st1_r.w_base;
    st2_nxt.m_old  = m_rd_r;
    st2_nxt.mem    = mem_rd_r;
    st2_nxt.pv     = 50'(st1_r.g) * 50'($signed({1'b0, omv}));
    st2_nxt.gg     = 64'(ga) * 64'(ga);

    // Stage 3: new momentum and the rounded squared gradient.
    inc        = st2_r.warm_v ? 64'(st2_r.g) : 64'(rnd_q16(64'(st2_r.pv)));
    st3_nxt    = st2_r;
    st3_nxt.m  = sat32(64'(st2_r.m_old) + inc);
    st3_nxt.sq = MEM_W'((st2_r.gg + RND_HALF) >> 16);

    // Stage 4: scaled memory increment, numerator and momentum decay products.
    mm          = st3_r.m[31] ? 32'(-st3_r.m) : 32'(st3_r.m);
    st4_nxt     = st3_r;
    st4_nxt.pa  = 64'(st3_r.sq) * 64'(oma);
    st4_nxt.num = NUM_W'(lr_r) * NUM_W'(mm);
    st4_nxt.pm  = 49'(st3_r.m) * 49'($signed({1'b0, visc_r}));

    // Stage 5: memory update and the root operand.
    add  = st4_r.warm_a ? st4_r.sq : MEM_W'((st4_r.pa + RND_HALF) >> 16);
    msum = (MEM_W + 1)'(st4_r.mem) + (MEM_W + 1)'(add);
    if (!ada_on) begin
      mem5 = st4_r.mem;
    end else if (msum[MEM_W]) begin
      mem5 = MEM_MAX;
    end else begin
      mem5 = msum[MEM_W-1:0];
    end
    eps          = ada_on ? EPS_SMALL : EPS_ONE;
    st5_nxt      = st4_r;
    st5_nxt.mem  = mem5;
    st5_nxt.x    = (64'(mem5) + eps) << ROOT_PRESHIFT;
    st5_nxt.mdec = 32'(rnd_q16(64'(st4_r.pm)));

    // Stage 6: memory decay product.
    st6_nxt      = st5_r;
    st6_nxt.pmem = 64'(st5_r.mem) * 64'(ada_r);

    // Stage 7: decayed memory.
    st7_nxt     = st6_r;
    st7_nxt.mem = ada_on ? MEM_W'((st6_r.pmem + RND_HALF) >> 16) : st6_r.mem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[5:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r <= st1_nxt;
      st2_r <= st2_nxt;
      st3_r <= st3_nxt;
      st4_r <= st4_nxt;
      st5_r <= st5_nxt;
      st6_r <= st6_nxt;
      st7_r <= st7_nxt;
    end
  end

  // Square root of the memory term, then the quotient.
  sq_st_t sq_in;
  sq_st_t sq_out;
  logic   sq_out_v;
  logic   sq_hit;
  dv_st_t dv_in;
  dv_st_t dv_out;
  logic   dv_out_v;
  logic   dv_hit;

  always_comb begin
    sq_in           = '0;
    sq_in.rem       = st7_r.x;
    sq_in.num       = st7_r.num;
    sq_in.sb.action = st7_r.action;
    sq_in.sb.idx    = st7_r.idx;
    sq_in.sb.w_base = st7_r.w_base;
    sq_in.sb.neg    = st7_r.m[31];
    sq_in.sb.mdec   = st7_r.mdec;
    sq_in.sb.mem    = st7_r.mem;
  end

  mrwu_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (fv_r[6]),
    .in_s      (sq_in),
    .probe_idx (in_idx),
    .hit       (sq_hit),
    .out_v     (sq_out_v),
    .out_s     (sq_out)
  );

  always_comb begin
    dv_in     = '0;
    dv_in.num = sq_out.num;
    dv_in.dsr = sq_out.res[31:0];
    dv_in.sb  = sq_out.sb;
  end

  mrwu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (sq_out_v),
    .in_s      (dv_in),
    .probe_idx (in_idx),
    .hit       (dv_hit),
    .out_v     (dv_out_v),
    .out_s     (dv_out)
  );

  // An entry may not be read again until its write back has happened.
  always_comb begin
    hazard = sq_hit || dv_hit;
    if (fv_r[0] && st1_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[1] && st2_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[2] && st3_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[3] && st4_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[4] && st5_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[5] && st6_r.idx == in_idx) hazard = 1'b1;
    if (fv_r[6] && st7_r.idx == in_idx) hazard = 1'b1;
  end

  // Final step: halve the Q.25 quotient with rounding, apply the sign and
  // subtract from the weight with saturation.
  logic [NUM_W-1:0]   d_mag;
  logic signed [63:0] delta;
  logic signed [31:0] w_new;
  out_t               res;

  always_comb begin
    d_mag = (dv_out.q + NUM_W'(1)) >> 1;
    delta = dv_out.sb.neg ? -$signed(64'(d_mag)) : $signed(64'(d_mag));
    w_new = sat32(64'(dv_out.sb.w_base) - delta);
    res.entry_out  = ENTRY_W'(dv_out.sb.idx);
    res.weight_out = (dv_out.sb.action == ACT_UPDATE) ? w_new : dv_out.sb.w_base;
  end

  // Write back, shared with the clearing pass.
  logic             wb_en;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_addr;
  logic signed [31:0] mo_wdata;
  logic [MEM_W-1:0]   me_wdata;

  assign wb_en    = adv && dv_out_v;
  assign tbl_we   = wb_en || clr_r;
  assign tbl_addr = clr_r ? clr_idx_r : dv_out.sb.idx;
  assign mo_wdata = (!clr_r && dv_out.sb.action == ACT_UPDATE) ? dv_out.sb.mdec : '0;
  assign me_wdata = (!clr_r && dv_out.sb.action == ACT_UPDATE) ? dv_out.sb.mem : '0;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mo_mem[tbl_addr] <= mo_wdata;
      me_mem[tbl_addr] <= me_wdata;
    end
    if (wb_en) begin
      wt_mem[dv_out.sb.idx] <= res.weight_out;
    end
  end

  // Output register: while a result waits, the whole pipeline holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_out_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pipeline is empty for the whole clearing pass.
  `MRWU_ASSERT_IMPL(a_clear_empty, clr_r, fv_r == 7'd0 && !sq_out_v && !dv_out_v, "pipeline busy during table clearing")
  // Clearing happens once after reset.
  `MRWU_ASSERT_NEXT(a_clear_once, !clr_r, !clr_r, "table clearing restarted")
  // Only an accepted end-of-pass update moves the iteration counter.
  `MRWU_ASSERT_NEXT(a_count_hold, !(in_fire && in_data.action == ACT_UPDATE && in_data.end_of_pass), $stable(count_r), "iteration counter moved without end of pass")
  // A stalled result blocks new transactions.
  `MRWU_ASSERT_IMPL(a_stall_blocks, out_valid_r && !out_ready, !in_ready, "transaction accepted while pipeline stalled")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the momentum and RMS weight update engine.
`timescale 1ns / 1ps

module tb;
  import mrwu_pkg::*;

  // A directed row may start with a register write, made once the engine has
  // gone idle. A row whose weight can be seen at a glance carries that value;
  // the predictor covers every other row.
  typedef struct {
    bit                 cfg_en;
    logic [1:0]         cfg_reg;
    logic [23:0]        cfg_val;
    in_t                item;
    bit                 known;
    logic signed [31:0] known_w;
  } dir_row_t;

  typedef struct {
    bit                 known;
    logic signed [31:0] w;
  } known_t;

  localparam int N_DIR = 19;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the engine state, kept by the predictor.
  logic signed [31:0] weight_tbl [ENTRIES];
  logic signed [31:0] mom_tbl    [ENTRIES];
  logic [47:0]        sqmem_tbl  [ENTRIES];
  logic [31:0]        pass_count;
  logic [23:0]        lr_shadow;
  logic [15:0]        visc_shadow;
  logic [15:0]        ada_shadow;

  out_t   weight_q [$];
  known_t known_q  [$];
  int     errors = 0;

  // Stimulus bookkeeping: updates only ever go to entries already loaded.
  bit     was_loaded [ENTRIES];
  int     loaded_list [$];
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;

  dir_row_t dir_tbl [0:N_DIR-1] = '{
    '{0, REG_LEARNING_RATE, 24'd0, '{ACT_LOAD, 12'd0, 32'sh0, 32'sh0, 1'b0}, 1, 32'sh0},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_LOAD, 12'd4095, 32'sh7FFF_FFFF, 32'sh0, 1'b0}, 1, 32'sh7FFF_FFFF},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_LOAD, 12'd1, 32'sh8000_0000, 32'sh0, 1'b0}, 1, 32'sh8000_0000},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_LOAD, 12'd2, 32'sh0100_0000, 32'sh0, 1'b0}, 1, 32'sh0100_0000},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd0, 32'shFFFF_FFFF, 32'sh0, 1'b0}, 1, 32'sh0},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd4095, 32'sh0, 32'sh8000_0000, 1'b0}, 1, 32'sh7FFF_FFFF},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd1, 32'sh0, 32'sh7FFF_FFFF, 1'b0}, 1, 32'sh8000_0000},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'sh0012_3456, 1'b1}, 0, 32'sh0},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_LOAD, 12'd3, 32'sh1234_5678, 32'shFFFF_FFFF, 1'b1}, 1, 32'sh1234_5678},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'shFFF0_0000, 1'b1}, 0, 32'sh0},
    '{1, REG_ADAGRAD, 24'd65535,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'sh7FFF_FFFF, 1'b0}, 0, 32'sh0},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'sh8000_0000, 1'b0}, 0, 32'sh0},
    '{1, REG_ADAGRAD, 24'd1,
      '{ACT_UPDATE, 12'd4095, 32'sh0, 32'sh0100_0000, 1'b0}, 0, 32'sh0},
    '{1, REG_LEARNING_RATE, 24'd0,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'sh7FFF_FFFF, 1'b0}, 0, 32'sh0},
    '{1, REG_LEARNING_RATE, 24'hFF_FFFF,
      '{ACT_UPDATE, 12'd1, 32'sh0, 32'sh7FFF_FFFF, 1'b0}, 0, 32'sh0},
    '{1, REG_VISCOSITY, 24'd0,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'sh4000_0000, 1'b1}, 0, 32'sh0},
    '{1, REG_VISCOSITY, 24'd65535,
      '{ACT_UPDATE, 12'd2, 32'sh0, 32'shC000_0000, 1'b0}, 0, 32'sh0},
    '{1, REG_ADAGRAD, 24'd0,
      '{ACT_UPDATE, 12'd0, 32'sh0, 32'sh0001_0000, 1'b0}, 0, 32'sh0},
    '{0, REG_LEARNING_RATE, 24'd0,
      '{ACT_LOAD, 12'd0, 32'shFFFF_FFFF, 32'sh0, 1'b0}, 1, 32'shFFFF_FFFF}
  };

  momentum_rms_weight_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. The slowest correct run, with every transaction
  // waiting out a full pipeline pass plus the longest gaps, stays far below.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor arithmetic.
  // ------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Divide by 2^16, rounding to nearest with ties away from zero.
  function automatic longint round_away16(input longint v);
    longint unsigned mg;
    mg = (v < 0) ? longint'(-v) : longint'(v);
    mg = (mg + 64'd32768) >> 16;
    return (v < 0) ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - res - b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Works out the weight that one transaction leaves in its entry and
  // advances the shadow state exactly as the engine does.
  function automatic out_t predict_weight(input in_t it);
    logic [11:0]     e;
    longint          w, g, inc, m, delta;
    longint unsigned omv, oma, ga, sq, add, mem, eps, root, num, q, d;
    bit              warm_v, warm_a;
    out_t            r;
    e = it.entry_index;
    if (it.action == ACT_LOAD) begin
      w = longint'(it.weight_in);
      weight_tbl[e] = it.weight_in;
      mom_tbl[e] = '0;
      sqmem_tbl[e] = '0;
    end else begin
      g = longint'(it.gradient);
      omv = 64'd65536 - visc_shadow;
      warm_v = (longint'(pass_count) * omv) < 64'd65536;
      inc = warm_v ? g : round_away16(g * longint'(omv));
      m = clamp32(longint'(mom_tbl[e]) + inc);
      mem = sqmem_tbl[e];
      if (ada_shadow != 0) begin
        // Memory only grows while normalization is enabled.
        oma = 64'd65536 - ada_shadow;
        warm_a = (longint'(pass_count) * oma) < 64'd65536;
        ga = (g < 0) ? longint'(-g) : longint'(g);
        sq = (ga * ga + 64'd32768) >> 16;
        add = warm_a ? sq : (sq * oma + 64'd32768) >> 16;
        mem = mem + add;
        if (mem > MEM_MAX) mem = MEM_MAX;
        eps = EPS_SMALL;
      end else begin
        eps = EPS_ONE;
      end
      root = floor_sqrt((mem + eps) << ROOT_PRESHIFT);
      num = longint'(lr_shadow) * ((m < 0) ? longint'(-m) : longint'(m));
      q = num / root;
      d = (q + 1) >> 1;
      delta = (m < 0) ? -longint'(d) : longint'(d);
      w = clamp32(longint'(weight_tbl[e]) - delta);
      weight_tbl[e] = w[31:0];
      mom_tbl[e] = 32'(round_away16(m * longint'(visc_shadow)));
      if (ada_shadow != 0) mem = (mem * longint'(ada_shadow) + 64'd32768) >> 16;
      sqmem_tbl[e] = mem[47:0];
      if (it.end_of_pass && pass_count != 32'hFFFF_FFFF) pass_count = pass_count + 1;
    end
    r.entry_out  = e;
    r.weight_out = w[31:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Input monitor: every accepted transaction gets its expected result.
  // Known values from the directed table take the place of the prediction.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    out_t   p;
    known_t k;
    if (rst_n && in_valid && in_ready) begin
      p = predict_weight(in_data);
      k = known_q.pop_front();
      if (k.known) p.weight_out = k.w;
      weight_q.push_back(p);
    end
  end

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_t x;
    if (rst_n && out_valid && out_ready) begin
      if (weight_q.size() == 0) begin
        $display("%0t: unexpected result, entry %0d weight %h", $time,
                 out_data.entry_out, out_data.weight_out);
        errors++;
      end else begin
        x = weight_q.pop_front();
        if (out_data.entry_out !== x.entry_out) begin
          $display("%0t: entry_out expected %0d actual %0d", $time,
                   x.entry_out, out_data.entry_out);
          errors++;
        end
        if (out_data.weight_out !== x.weight_out) begin
          $display("%0t: weight_out expected %h actual %h", $time,
                   x.weight_out, out_data.weight_out);
          errors++;
        end
      end
    end
  end

  // Receiver: a random stall before every result, none in quiet phases, and
  // one long hold-off on request so that the pipeline backs up to its input.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ------------------------------------------------------------------
  // Sender side.
  // ------------------------------------------------------------------

  // Offers one transaction after a random gap and holds it until accepted.
  // With no gap, valid simply stays high into the next transaction.
  task automatic send_item(input in_t it, input bit known, input logic signed [31:0] kw);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    known_q.push_back('{known, kw});
    if (it.action == ACT_LOAD && !was_loaded[it.entry_index]) begin
      was_loaded[it.entry_index] = 1'b1;
      loaded_list.push_back(it.entry_index);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits for every expected result, then idles before returning.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // One register write, after which the write port is left idle before returning.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEARNING_RATE: lr_shadow = val;
      REG_VISCOSITY:     visc_shadow = val[15:0];
      REG_ADAGRAD:       ada_shadow = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly updates with random content on loaded entries, with half of the loads
  // on entries 0 to 15 so that hazards and long momentum histories are common.
  function automatic in_t random_item();
    in_t it;
    it.weight_in   = $urandom;
    it.gradient    = $urandom;
    it.end_of_pass = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 3) != 0) begin
      it.gradient = $signed(it.gradient) >>> $urandom_range(3, 20);
    end
    if (loaded_list.size() == 0 || $urandom_range(0, 4) == 0) begin
      it.action = ACT_LOAD;
      it.entry_index = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 15)) : 12'($urandom);
      if ($urandom_range(0, 1) == 0) it.weight_in = $signed(it.weight_in) >>> 6;
    end else begin
      it.action = ACT_UPDATE;
      it.entry_index = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    end
    return it;
  endfunction

  initial begin
    in_t         it;
    logic [23:0] lr_v;
    logic [15:0] vi_v, ad_v;
    lr_shadow   = LR_RESET;
    visc_shadow = VISC_RESET;
    ada_shadow  = ADA_RESET;
    pass_count  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      mom_tbl[i]    = '0;
      sqmem_tbl[i]  = '0;
      weight_tbl[i] = '0;
      was_loaded[i] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, both actions, ignored fields, saturation.
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tbl[i].cfg_en) begin
        wait_drained();
        write_reg(dir_tbl[i].cfg_reg, dir_tbl[i].cfg_val);
      end
      send_item(dir_tbl[i].item, dir_tbl[i].known, dir_tbl[i].known_w);
    end

    // Random part: several register settings, extremes included. Phase 3
    // runs with no idling and a long receiver hold-off.
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      case (ph)
        0: begin lr_v = LR_RESET; vi_v = VISC_RESET; ad_v = ADA_RESET; end
        1: begin lr_v = 24'hFF_FFFF; vi_v = 16'd0; ad_v = 16'd65535; end
        2: begin lr_v = 24'd0; vi_v = 16'd65535; ad_v = 16'd0; end
        5: begin lr_v = $urandom; vi_v = $urandom; ad_v = 16'd1; end
        default: begin lr_v = $urandom; vi_v = $urandom; ad_v = $urandom; end
      endcase
      write_reg(REG_LEARNING_RATE, lr_v);
      write_reg(REG_VISCOSITY, {8'd0, vi_v});
      write_reg(REG_ADAGRAD, {8'd0, ad_v});
      quiet = (ph == 3) || (ph == 6);
      if (ph == 3) begin
        // Distinct entries so that nothing but the hold-off stalls the input.
        hold_req = 1'b1;
        for (int k = 0; k < 120; k++) begin
          it = random_item();
          it.action = (k < 60) ? ACT_LOAD : ACT_UPDATE;
          it.entry_index = 12'(100 + (k % 60));
          send_item(it, 1'b0, '0);
        end
      end
      for (int k = 0; k < 200; k++) begin
        send_item(random_item(), 1'b0, '0);
      end
    end

    wait_drained();
    if (errors == 0 && known_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrwu_pkg.sv
rtl/mrwu_isqrt.sv
rtl/mrwu_div.sv
rtl/momentum_rms_weight_update.sv
tb/tb.sv
